// ===== rtl/psac_pkg.sv =====
package psac_pkg;

  localparam int POS_W     = 26;
  localparam int DIFF_W    = 27;
  localparam int SPEED_W   = 16;
  localparam int INV_W     = 16;
  localparam int SEGN_W    = 5;
  localparam int SEGD_W    = 28;
  localparam int RAD_W     = 54;
  localparam int ROOT_W    = 27;
  localparam int MUL_W     = 29;
  localparam int PROD_W    = 2 * MUL_W;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_INV_STEP_TIME     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEPS_PER_SEGMENT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_SEGMENT_TIME  = 2'd2;

  localparam logic [INV_W-1:0]  INV_STEP_TIME_RST     = 16'd12800;
  localparam logic [SEGN_W-1:0] STEPS_PER_SEGMENT_RST = 5'd10;
  localparam logic [INV_W-1:0]  INV_SEGMENT_TIME_RST  = 16'd1280;

  localparam int MAX_STEPS_PER_SEGMENT_DEF = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_ROOT,
    ST_SPD,
    ST_SPDU,
    ST_SSPD,
    ST_SSPDU,
    ST_ACC,
    ST_ACCU,
    ST_FIN
  } psac_state_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } psac_sqrt_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } psac_sqrt_stat_t;

endpackage

// ===== rtl/psac_in_if.sv =====
interface psac_in_if import psac_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     first_point;
  logic                     last_point;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [SPEED_W-1:0] initial_speed;

  modport source (output valid, first_point, last_point, pos_x, pos_y, initial_speed,
                  input ready);
  modport sink   (input valid, first_point, last_point, pos_x, pos_y, initial_speed,
                  output ready);
endinterface

// ===== rtl/psac_out_if.sv =====
interface psac_out_if import psac_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [SPEED_W-1:0] peak_speed;
  logic signed [SPEED_W-1:0] peak_accel;

  modport source (output valid, peak_speed, peak_accel, input ready);
  modport sink   (input valid, peak_speed, peak_accel, output ready);
endinterface

// ===== rtl/psac_sqrt.sv =====
module psac_sqrt import psac_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  psac_sqrt_req_t      req,
  output psac_sqrt_stat_t     stat,
  output logic [ROOT_W-1:0]   root
);

  localparam int CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad;
  logic [SEGD_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  logic [SEGD_W+1:0] rem_sh;
  logic [SEGD_W+1:0] trial;
  logic              fits;
  logic              last_iter;

  // one result bit per cycle, restoring
  assign rem_sh    = {rem, rad[RAD_W-1 -: 2]};
  assign trial     = {1'b0, root, 2'b01};
  assign fits      = rem_sh >= trial;
  assign last_iter = cnt == CNT_W'(ROOT_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (last_iter) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad  <= req.radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (fits) begin
        rem  <= SEGD_W'(rem_sh - trial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[SEGD_W-1:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = busy && last_iter;

endmodule

// ===== rtl/path_speed_accel_checker_top.sv =====
// Path speed and acceleration checker.
// points: one word per path point (first_point, last_point, pos_x, pos_y,
// initial_speed). result: one word (peak_speed, peak_accel) after each point
// flagged last_point, none otherwise. Both are valid/ready channels.
// cfg_we/cfg_index/cfg_data write inv_step_time (0), steps_per_segment (1)
// and inv_segment_time (2); write only while no point is in flight.
// One point is worked at a time; points.ready is low while it is busy.
// A first point starts a new path and skips the arithmetic. A later point runs
// the bit-serial square root, plus the segment speed and acceleration steps when
// it closes a segment; one shared 29x29 multiplier handles squares, speeds and acceleration.
// The result word is held in an output register; the next point is accepted
// while it waits. A last point whose result finds that register still full
// holds the block until result.ready takes the waiting word.
// Reset (rst, synchronous) restores the register defaults and clears all
// path state, as if a path had begun at (0,0) with initial speed 0.
module path_speed_accel_checker_top import psac_pkg::*; #(
  parameter int MAX_STEPS_PER_SEGMENT = MAX_STEPS_PER_SEGMENT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  psac_in_if.sink                points,
  psac_out_if.source             result
);

  localparam int CW = $clog2(MAX_STEPS_PER_SEGMENT + 1);
  localparam int NW = (CW > SEGN_W) ? CW : SEGN_W;

  psac_state_t state, state_next;

  logic [INV_W-1:0]  inv_step_time;
  logic [SEGN_W-1:0] steps_per_segment;
  logic [INV_W-1:0]  inv_segment_time;

  logic signed [POS_W-1:0]   prev_x, prev_y;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic                      last_r;
  logic [CW-1:0]             cnt;
  logic [SEGD_W-1:0]         segdist;
  logic signed [SPEED_W-1:0] last_seg_speed;
  logic signed [SPEED_W-1:0] seg_speed;
  logic [SPEED_W-1:0]        max_speed;
  logic signed [SPEED_W-1:0] max_accel;
  logic [RAD_W-1:0]          sq;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  psac_sqrt_req_t    sqrt_req;
  psac_sqrt_stat_t   sqrt_stat;
  logic [ROOT_W-1:0] root;

  logic                      load_out;
  logic [NW-1:0]             seg_n, cnt_inc;
  logic                      seg_hit;
  logic [SPEED_W-1:0]        spd_sat;
  logic [SEGD_W:0]           segdist_sum;
  logic signed [SPEED_W:0]   diff;
  logic signed [SPEED_W-1:0] acc_sat;

  function automatic logic [SPEED_W:0] mag17(logic signed [SPEED_W-1:0] v);
    logic [SPEED_W:0] e;
    e = {v[SPEED_W-1], v};
    return v[SPEED_W-1] ? (~e + (SPEED_W+1)'(1)) : e;
  endfunction

  psac_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (sqrt_req),
    .stat (sqrt_stat),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_step_time     <= INV_STEP_TIME_RST;
      steps_per_segment <= STEPS_PER_SEGMENT_RST;
      inv_segment_time  <= INV_SEGMENT_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_STEP_TIME:     inv_step_time     <= cfg_data[INV_W-1:0];
        REG_STEPS_PER_SEGMENT: steps_per_segment <= cfg_data[SEGN_W-1:0];
        REG_INV_SEGMENT_TIME:  inv_segment_time  <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // segment length clamped to 1..MAX_STEPS_PER_SEGMENT
  always_comb begin
    if (steps_per_segment == '0) begin
      seg_n = NW'(1);
    end else if (NW'(steps_per_segment) > NW'(MAX_STEPS_PER_SEGMENT)) begin
      seg_n = NW'(MAX_STEPS_PER_SEGMENT);
    end else begin
      seg_n = NW'(steps_per_segment);
    end
  end
  assign cnt_inc = NW'(cnt) + NW'(1);
  assign seg_hit = cnt_inc >= seg_n;

  assign spd_sat     = (prod[PROD_W-1:24] != '0) ? '1 : prod[23:8];
  assign segdist_sum = {1'b0, segdist} + (SEGD_W+1)'(root);
  assign diff        = {seg_speed[SPEED_W-1], seg_speed}
                     - {last_seg_speed[SPEED_W-1], last_seg_speed};

  always_comb begin
    if ((&prod[PROD_W-1:23]) || (~|prod[PROD_W-1:23])) begin
      acc_sat = prod[23:8];
    end else if (prod[PROD_W-1]) begin
      acc_sat = {1'b1, {(SPEED_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(SPEED_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    points.ready      = 1'b0;
    mul_a             = '0;
    mul_b             = '0;
    sqrt_req.start    = 1'b0;
    sqrt_req.radicand = sq + prod[RAD_W-1:0];
    load_out          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        points.ready = 1'b1;
        if (points.valid) begin
          state_next = points.first_point ? ST_FIN : ST_SQX;
        end
      end
      ST_SQX: begin
        mul_a      = MUL_W'(dx);
        mul_b      = MUL_W'(dx);
        state_next = ST_SQY;
      end
      ST_SQY: begin
        mul_a      = MUL_W'(dy);
        mul_b      = MUL_W'(dy);
        state_next = ST_SUM;
      end
      ST_SUM: begin
        sqrt_req.start = 1'b1;
        state_next     = ST_ROOT;
      end
      ST_ROOT: begin
        if (sqrt_stat.done) begin
          state_next = ST_SPD;
        end
      end
      ST_SPD: begin
        mul_a      = MUL_W'($signed({1'b0, root}));
        mul_b      = MUL_W'($signed({1'b0, inv_step_time}));
        state_next = ST_SPDU;
      end
      ST_SPDU: begin
        state_next = seg_hit ? ST_SSPD : ST_FIN;
      end
      ST_SSPD: begin
        mul_a      = MUL_W'($signed({1'b0, segdist}));
        mul_b      = MUL_W'($signed({1'b0, inv_segment_time}));
        state_next = ST_SSPDU;
      end
      ST_SSPDU: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        mul_a      = MUL_W'(diff);
        mul_b      = MUL_W'($signed({1'b0, inv_segment_time}));
        state_next = ST_ACCU;
      end
      ST_ACCU: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!last_r) begin
          state_next = ST_IDLE;
        end else if (!result.valid || result.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x         <= '0;
      prev_y         <= '0;
      cnt            <= '0;
      segdist        <= '0;
      last_seg_speed <= '0;
      max_speed      <= '0;
      max_accel      <= '0;
      last_r         <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (points.valid) begin
            last_r <= points.last_point;
            prev_x <= points.pos_x;
            prev_y <= points.pos_y;
            dx     <= DIFF_W'(points.pos_x) - DIFF_W'(prev_x);
            dy     <= DIFF_W'(points.pos_y) - DIFF_W'(prev_y);
            if (points.first_point) begin
              cnt            <= '0;
              segdist        <= '0;
              last_seg_speed <= points.initial_speed;
              max_speed      <= '0;
              max_accel      <= '0;
            end
          end
        end
        ST_SQY: begin
          sq <= prod[RAD_W-1:0];
        end
        ST_SPDU: begin
          if (spd_sat > max_speed) begin
            max_speed <= spd_sat;
          end
          segdist <= segdist_sum[SEGD_W] ? '1 : segdist_sum[SEGD_W-1:0];
          cnt     <= seg_hit ? '0 : cnt_inc[CW-1:0];
        end
        ST_SSPDU: begin
          seg_speed <= (prod[PROD_W-1:23] != '0) ? {1'b0, {(SPEED_W-1){1'b1}}}
                                                 : prod[23:8];
        end
        ST_ACCU: begin
          if (mag17(max_accel) < mag17(acc_sat)) begin
            max_accel <= acc_sat;
          end
          segdist        <= '0;
          last_seg_speed <= seg_speed;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.peak_speed <= max_speed;
      result.peak_accel <= max_accel;
    end
  end

`ifndef SYNTHESIS
  a_speed_monotone: assert property (@(posedge clk) disable iff (rst)
    !(points.valid && points.ready && points.first_point)
      |=> max_speed >= $past(max_speed))
    else $error("peak speed dropped within a path");

  a_accel_monotone: assert property (@(posedge clk) disable iff (rst)
    !(points.valid && points.ready && points.first_point)
      |=> mag17(max_accel) >= mag17($past(max_accel)))
    else $error("peak acceleration magnitude dropped within a path");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    NW'(cnt) < NW'(MAX_STEPS_PER_SEGMENT))
    else $error("segment step count out of range");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == ST_FIN) && $past(last_r))
    else $error("result word raised outside a last point");
`endif

endmodule
